// ----- rtl/fclt_pkg.sv -----
// Shared types and constants for the four-channel linear tween.
package fclt_pkg;

    // Channel slots carried by every request and every result, used or not
    localparam int LANE_SLOTS = 4;
    localparam int MODE_W     = 2;
    localparam int DUR_W      = 16;
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    typedef enum logic [MODE_W-1:0] {
        MODE_PLACE  = 2'd0,
        MODE_MOVE   = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_SAMPLE = 2'd3
    } mode_t;

    // Per-cycle commands from the sequencer to every lane
    typedef struct packed {
        logic place;
        logic move;
        logic copy_prev;
        logic snap;
        logic ramp_mul;
        logic div_step;
        logic ramp_commit;
        logic blend_mul;
        logic blend_sel;
    } lane_ctrl_t;

endpackage

// ----- rtl/four_channel_linear_tween_top.sv -----
// Top level of the four-channel linear tween: request sequencer, lanes and result stage.
//
//  channel   dir  payload                                              handshake
//  s_axis    in   tuser: mode; tdata: x, y, rotation, scale,           tvalid/tready
//                 duration_ticks, alpha
//  m_axis    out  tdata: out_x, out_y, out_rotation, out_scale, moving  tvalid/tready
//
// Place, move, sample, an idle tick and the tick that ends a ramp go from accept to the
// done state and then to the output register. A tick that advances a ramp short of its
// end passes through the multiply, divide and commit states before done, the divide state
// running the one-bit-per-cycle restoring divider that every lane runs.
// rst_n clears all channel values, counters, the motion flag and the output valid flag.
// One request is worked at a time; the next is taken as soon as the result has
// moved to the output register, and a stalled result only holds the sequencer
// when a further result is ready behind it.
module four_channel_linear_tween_top
    import fclt_pkg::*;
#(
    parameter int VALUE_WIDTH      = 32,
    parameter int TICK_COUNT_WIDTH = 16,
    parameter int CHANNEL_COUNT    = 4
)
(
    input  logic clk,
    input  logic rst_n,
    // tdata from bit 0 up: value_x, value_y, value_rotation, value_scale,
    // duration_ticks (16), alpha (17), zero fill
    input  logic                                              s_axis_tvalid,
    output logic                                              s_axis_tready,
    input  logic [((LANE_SLOTS*VALUE_WIDTH+DUR_W+ALPHA_W+7)/8)*8-1:0] s_axis_tdata,
    // tuser: mode
    input  logic [MODE_W-1:0]                                 s_axis_tuser,
    // tdata from bit 0 up: out_x, out_y, out_rotation, out_scale, moving, zero fill
    output logic                                              m_axis_tvalid,
    input  logic                                              m_axis_tready,
    output logic [((LANE_SLOTS*VALUE_WIDTH+1+7)/8)*8-1:0]     m_axis_tdata
);

    localparam int QW    = VALUE_WIDTH + 1;
    localparam int CNT_W = $clog2(QW);
    localparam int DUR_LSB   = LANE_SLOTS * VALUE_WIDTH;
    localparam int ALPHA_LSB = DUR_LSB + DUR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_COMMIT,
        ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [TICK_COUNT_WIDTH-1:0] progress_reg, progress_next;
    logic [TICK_COUNT_WIDTH-1:0] total_reg, total_next;
    logic                        active_reg, active_next;
    logic                        blend_sel_reg, blend_sel_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    logic                        in_accept;
    mode_t                       mode;
    logic [DUR_W-1:0]            duration;
    logic [TICK_COUNT_WIDTH-1:0] duration_t;
    logic [ALPHA_W-1:0]          alpha_raw, alpha_sat;
    logic [TICK_COUNT_WIDTH-1:0] progress_inc;
    logic                        ramp_end;
    logic                        out_load;
    lane_ctrl_t                  ctrl;
    logic [CHANNEL_COUNT-1:0][VALUE_WIDTH-1:0] lane_value;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign mode          = mode_t'(s_axis_tuser);

    // Take the low tick bits of the duration; a zero length counts as one tick
    assign duration   = s_axis_tdata[DUR_LSB +: DUR_W];
    assign duration_t = TICK_COUNT_WIDTH'(duration);

    // Clamp alpha to one
    assign alpha_raw = s_axis_tdata[ALPHA_LSB +: ALPHA_W];
    assign alpha_sat = (alpha_raw > ALPHA_ONE) ? ALPHA_ONE : alpha_raw;

    assign progress_inc = progress_reg + TICK_COUNT_WIDTH'(1);
    assign ramp_end     = (total_reg == '0) || (progress_inc >= total_reg);

    // Move the finished result out once the output register is free
    assign out_load = (state_reg == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

    always_comb
    begin
        state_next     = state_reg;
        progress_next  = progress_reg;
        total_next     = total_reg;
        active_next    = active_reg;
        blend_sel_next = blend_sel_reg;
        cnt_next       = cnt_reg;
        ctrl           = '0;
        ctrl.blend_sel = blend_sel_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    blend_sel_next = 1'b0;
                    state_next     = ST_DONE;
                    case (mode)
                        MODE_PLACE:
                        begin
                            ctrl.place    = 1'b1;
                            progress_next = '0;
                            total_next    = '0;
                            active_next   = 1'b0;
                        end
                        MODE_MOVE:
                        begin
                            ctrl.move     = 1'b1;
                            progress_next = '0;
                            total_next    = (duration_t == '0) ? TICK_COUNT_WIDTH'(1)
                                                                : duration_t;
                            active_next   = 1'b1;
                        end
                        MODE_TICK:
                        begin
                            ctrl.copy_prev = 1'b1;
                            if (active_reg)
                            begin
                                progress_next = progress_inc;
                                if (ramp_end)
                                begin
                                    ctrl.snap   = 1'b1;
                                    active_next = 1'b0;
                                end
                                else
                                    state_next = ST_MUL;
                            end
                        end
                        MODE_SAMPLE:
                        begin
                            ctrl.blend_mul = 1'b1;
                            blend_sel_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                ctrl.ramp_mul = 1'b1;
                cnt_next      = CNT_W'(QW - 1);
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_COMMIT;
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            end
            ST_COMMIT:
            begin
                ctrl.ramp_commit = 1'b1;
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            progress_reg  <= '0;
            total_reg     <= '0;
            active_reg    <= 1'b0;
            blend_sel_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            progress_reg  <= progress_next;
            total_reg     <= total_next;
            active_reg    <= active_next;
            blend_sel_reg <= blend_sel_next;
            cnt_reg       <= cnt_next;
        end
    end

    // One lane per channel; all lanes share the tick counters and step in lockstep
    for (genvar g = 0; g < CHANNEL_COUNT; g++)
    begin : g_lane
        fclt_lane #(
            .VALUE_WIDTH      (VALUE_WIDTH),
            .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .value_in  (s_axis_tdata[g*VALUE_WIDTH +: VALUE_WIDTH]),
            .alpha     (alpha_sat),
            .progress  (progress_reg),
            .total     (total_reg),
            .value_out (lane_value[g])
        );
    end

    fclt_merge #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .lane_value    (lane_value),
        .moving        (active_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // A running ramp always has a nonzero length and has not reached its end
    a_active_total: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (total_reg != '0) && (progress_reg < total_reg))
        else $error("ramp active with progress outside its length");

    // Placing values always stops motion
    a_place_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_axis_tuser == MODE_PLACE)) |=> !active_reg)
        else $error("motion flag survived a place request");

    // The divider finishes before the new value is written
    a_commit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> ($past(state_reg) == ST_DIV) && ($past(cnt_reg) == '0))
        else $error("ramp commit without a finished division");

    // A result leaves the sequencer only from its done state
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid && (state_reg == ST_IDLE))
        else $error("result load out of sequence");

endmodule

// ----- rtl/fclt_lane.sv -----
// One channel: value state, ramp multiplier with restoring divider, blend unit.
module fclt_lane
    import fclt_pkg::*;
#(
    parameter int VALUE_WIDTH      = 32,
    parameter int TICK_COUNT_WIDTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lane_ctrl_t                  ctrl,
    input  logic [VALUE_WIDTH-1:0]      value_in,
    input  logic [ALPHA_W-1:0]          alpha,
    input  logic [TICK_COUNT_WIDTH-1:0] progress,
    input  logic [TICK_COUNT_WIDTH-1:0] total,
    output logic [VALUE_WIDTH-1:0]      value_out
);

    localparam int QW = VALUE_WIDTH + 1;                 // quotient bits
    localparam int PW = QW + TICK_COUNT_WIDTH;           // ramp product bits
    localparam int BW = VALUE_WIDTH + 1 + ALPHA_W + 1;   // blend product bits

    logic [VALUE_WIDTH-1:0] prev_reg, cur_reg, start_reg, target_reg;

    // Ramp datapath
    logic signed [QW-1:0]       ramp_diff;
    logic                       ramp_neg;
    logic [QW-1:0]              ramp_mag;
    logic [PW-1:0]              ramp_prod;
    logic [TICK_COUNT_WIDTH-1:0] rem_reg;
    logic [QW-1:0]              dq_reg;
    logic                       neg_reg;
    logic [TICK_COUNT_WIDTH:0]  trial;
    logic [TICK_COUNT_WIDTH:0]  trial_sub;
    logic                       trial_ge;
    logic [VALUE_WIDTH-1:0]     ramp_value;

    // Blend datapath
    logic signed [QW-1:0]       blend_diff;
    logic signed [BW-1:0]       blend_prod;
    logic signed [BW-1:0]       bprod_reg;
    logic signed [BW-1:0]       blend_shift;
    logic [VALUE_WIDTH-1:0]     blended;

    assign ramp_diff = $signed({target_reg[VALUE_WIDTH-1], target_reg})
                     - $signed({start_reg[VALUE_WIDTH-1], start_reg});
    assign ramp_neg  = ramp_diff[QW-1];
    assign ramp_mag  = ramp_neg ? (QW'(0) - QW'(ramp_diff)) : QW'(ramp_diff);
    assign ramp_prod = PW'(ramp_mag) * PW'(progress);

    // Remainder stays below total, so the trial fits one extra bit
    assign trial     = {rem_reg, dq_reg[QW-1]};
    assign trial_sub = trial - {1'b0, total};
    assign trial_ge  = (trial >= {1'b0, total});

    assign ramp_value = neg_reg ? (start_reg - dq_reg[VALUE_WIDTH-1:0])
                                : (start_reg + dq_reg[VALUE_WIDTH-1:0]);

    assign blend_diff  = $signed({cur_reg[VALUE_WIDTH-1], cur_reg})
                       - $signed({prev_reg[VALUE_WIDTH-1], prev_reg});
    assign blend_prod  = blend_diff * $signed({1'b0, alpha});
    assign blend_shift = bprod_reg >>> ALPHA_FRAC;
    assign blended     = prev_reg + blend_shift[VALUE_WIDTH-1:0];

    assign value_out = ctrl.blend_sel ? blended : cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            cur_reg    <= '0;
            start_reg  <= '0;
            target_reg <= '0;
        end
        else
        begin
            if (ctrl.place)
            begin
                prev_reg   <= value_in;
                cur_reg    <= value_in;
                start_reg  <= value_in;
                target_reg <= value_in;
            end
            if (ctrl.move)
            begin
                start_reg  <= cur_reg;
                target_reg <= value_in;
            end
            if (ctrl.copy_prev)
                prev_reg <= cur_reg;
            if (ctrl.snap)
                cur_reg <= target_reg;
            if (ctrl.ramp_commit)
                cur_reg <= ramp_value;
        end
    end

    // Divider and product registers carry payload only
    always_ff @(posedge clk)
    begin
        if (ctrl.ramp_mul)
        begin
            rem_reg <= ramp_prod[PW-1:QW];
            dq_reg  <= ramp_prod[QW-1:0];
            neg_reg <= ramp_neg;
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[TICK_COUNT_WIDTH-1:0]
                                : trial[TICK_COUNT_WIDTH-1:0];
            dq_reg  <= {dq_reg[QW-2:0], trial_ge};
        end
        if (ctrl.blend_mul)
            bprod_reg <= blend_prod;
    end

endmodule

// ----- rtl/fclt_merge.sv -----
// Result stage: gathers the lane values and the motion flag into the output register.
module fclt_merge
    import fclt_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int CHANNEL_COUNT = 4
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic [CHANNEL_COUNT-1:0][VALUE_WIDTH-1:0] lane_value,
    input  logic                                    moving,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((LANE_SLOTS*VALUE_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_W = ((LANE_SLOTS * VALUE_WIDTH + 1 + 7) / 8) * 8;

    logic [OUT_W-1:0] data_next;

    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++)
            data_next[i*VALUE_WIDTH +: VALUE_WIDTH] = lane_value[i];
        data_next[LANE_SLOTS*VALUE_WIDTH] = moving;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (load)
            m_axis_tvalid <= 1'b1;
        else if (m_axis_tready)
            m_axis_tvalid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            m_axis_tdata <= data_next;
    end

endmodule
